// ----- rtl/obdpps_pkg.sv -----
// ----------------------------------------------------------------------------
// OBD-II PID poll sequencer package
// Shared word types, phase encoding, constants and the priority encoder
// used by the sequencer step logic.
// ----------------------------------------------------------------------------
`default_nettype none

package obdpps_pkg;

  // Input word: either a timer tick or a received CAN frame.
  typedef struct packed {
    logic        opcode;
    logic [10:0] frame_id;
    logic [3:0]  frame_length;
    logic [7:0]  byte_zero;
    logic [7:0]  byte_one;
    logic [7:0]  byte_two;
    logic [7:0]  byte_three;
    logic [7:0]  byte_four;
    logic [7:0]  byte_five;
    logic [7:0]  byte_six;
  } in_word_t;

  // Result word: one request or one fault report.
  typedef struct packed {
    logic [5:0]  request_pid;
    logic [1:0]  fault_code;
    logic [31:0] controlled_pids;
  } out_word_t;

  // Configuration registers as held inside the block.
  typedef struct packed {
    logic [31:0] checked_pid_mask;
    logic [3:0]  discovery_tries;
    logic [15:0] response_timeout_ticks;
    logic [15:0] poll_period_ticks;
  } cfg_t;

  // Sequencer phase, one-hot.
  typedef enum logic [3:0] {
    PH_PENDING = 4'b0001,
    PH_WAIT    = 4'b0010,
    PH_POLL    = 4'b0100,
    PH_FAULT   = 4'b1000
  } phase_e;

  // Sequencer control state other than the tick counter.
  typedef struct packed {
    phase_e      phase;
    logic [3:0]  tries_used;
    logic [31:0] controlled;
    logic [5:0]  last_pid;
  } seq_state_t;

  // Opcodes of the input word.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_FRAME = 1'b1;

  // Fault codes.
  localparam logic [1:0] FAULT_NONE        = 2'd0;
  localparam logic [1:0] FAULT_NO_RESPONSE = 2'd1;
  localparam logic [1:0] FAULT_NO_PIDS     = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CHECKED_MASK = 2'd0;
  localparam logic [1:0] CFG_TRIES        = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT      = 2'd2;
  localparam logic [1:0] CFG_PERIOD       = 2'd3;

  // Register reset values.
  localparam logic [31:0] CHECKED_MASK_RST = 32'h1FFF_C002;
  localparam logic [3:0]  TRIES_RST        = 4'd5;
  localparam logic [15:0] TIMEOUT_RST      = 16'd100;
  localparam logic [15:0] PERIOD_RST       = 16'd20;

  // Protocol constants.
  localparam logic [10:0] REQ_ID         = 11'h7DF;
  localparam logic [10:0] RESP_ID_LOW    = 11'h7E8;
  localparam logic [10:0] RESP_ID_HIGH   = 11'h7EF;
  localparam logic [3:0]  RESP_DLC       = 4'd8;
  localparam logic [7:0]  RESP_MIN_LEN   = 8'd2;
  localparam logic [7:0]  MODE01_REPLY   = 8'h41;
  localparam logic [7:0]  PID_SUPPORTED  = 8'h00;

  // Position of the first set bit counted from bit 31 downward.
  function automatic logic [4:0] lead_pos(input logic [31:0] v);
    logic [4:0] pos;
    logic       found;
    pos   = '0;
    found = 1'b0;
    for (int i = 0; i < 32; i++) begin
      if (!found && v[31-i]) begin
        pos   = 5'(i);
        found = 1'b1;
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/obdpps_step.sv -----
// ----------------------------------------------------------------------------
// OBD-II PID poll sequencer step logic
// Computes the next sequencer state and the optional result word for one
// input word: response matching, timeout counting and round-robin PID choice.
// ----------------------------------------------------------------------------
`default_nettype none

module obdpps_step #(
  parameter int TIMER_BITS = 16
) (
  input  wire logic                    fire_i,
  input  wire obdpps_pkg::in_word_t    word_i,
  input  wire obdpps_pkg::cfg_t        cfg_i,
  input  wire obdpps_pkg::seq_state_t  state_i,
  input  wire logic [TIMER_BITS-1:0]   count_i,
  output      obdpps_pkg::seq_state_t  state_o,
  output      logic [TIMER_BITS-1:0]   count_o,
  output      logic                    emit_o,
  output      obdpps_pkg::out_word_t   result_o
);
  import obdpps_pkg::*;

  localparam int CmpW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  logic                  frame_ok;
  logic [31:0]           frame_bitmap;
  logic [31:0]           cb_new;
  logic [31:0]           cb_pick;
  logic [4:0]            start;
  logic [63:0]           rot;
  logic [4:0]            lead;
  logic [4:0]            hit_bit;
  logic [5:0]            pid_next;
  logic [TIMER_BITS-1:0] cnt_next;
  logic [15:0]           thr;
  logic [15:0]           limit;
  logic                  reached;

  // A supported-PID answer from one of the engine ECUs.
  assign frame_ok = (word_i.frame_id >= RESP_ID_LOW) && (word_i.frame_id <= RESP_ID_HIGH) &&
                    (word_i.frame_length == RESP_DLC) && (word_i.byte_zero > RESP_MIN_LEN) &&
                    (word_i.byte_one == MODE01_REPLY) && (word_i.byte_two == PID_SUPPORTED);

  assign frame_bitmap = {word_i.byte_three, word_i.byte_four, word_i.byte_five, word_i.byte_six};
  assign cb_new       = frame_bitmap & cfg_i.checked_pid_mask;

  // Rotating priority encoder: search starts at the bit after the last PID.
  assign cb_pick  = (state_i.phase == PH_POLL) ? state_i.controlled : cb_new;
  assign start    = state_i.last_pid[4:0];
  assign rot      = {cb_pick, cb_pick} << start;
  assign lead     = lead_pos(rot[63:32]);
  assign hit_bit  = start + lead;
  assign pid_next = {1'b0, hit_bit} + 6'd1;

  // Shared saturating tick counter; only one of the two waits is active.
  assign cnt_next = (&count_i) ? count_i : count_i + {{(TIMER_BITS-1){1'b0}}, 1'b1};
  assign thr      = (state_i.phase == PH_WAIT) ? cfg_i.response_timeout_ticks
                                               : cfg_i.poll_period_ticks;
  assign limit    = (thr == 16'd0) ? 16'd1 : thr;
  assign reached  = (CmpW'(cnt_next) >= CmpW'(limit)) || (&cnt_next);

  // Next state and result.
  always_comb begin
    state_o  = state_i;
    count_o  = count_i;
    emit_o   = 1'b0;
    result_o = '{request_pid: 6'd0, fault_code: FAULT_NONE,
                 controlled_pids: state_i.controlled};
    if (fire_i) begin
      unique case (state_i.phase)
        PH_PENDING, PH_WAIT: begin
          if (word_i.opcode == OP_FRAME) begin
            if (frame_ok) begin
              state_o.controlled       = cb_new;
              result_o.controlled_pids = cb_new;
              emit_o                   = 1'b1;
              if (cb_new == 32'd0) begin
                state_o.phase       = PH_FAULT;
                result_o.fault_code = FAULT_NO_PIDS;
              end else begin
                state_o.phase        = PH_POLL;
                state_o.last_pid     = pid_next;
                count_o              = '0;
                result_o.request_pid = pid_next;
              end
            end
          end else if (state_i.phase == PH_PENDING) begin
            state_o.phase      = PH_WAIT;
            state_o.tries_used = 4'd1;
            count_o            = '0;
            emit_o             = 1'b1;
          end else begin
            count_o = cnt_next;
            if (reached) begin
              count_o = '0;
              emit_o  = 1'b1;
              if (state_i.tries_used < cfg_i.discovery_tries) begin
                state_o.tries_used = state_i.tries_used + 4'd1;
              end else begin
                state_o.phase       = PH_FAULT;
                result_o.fault_code = FAULT_NO_RESPONSE;
              end
            end
          end
        end
        PH_POLL: begin
          if (word_i.opcode == OP_TICK) begin
            count_o = cnt_next;
            if (reached) begin
              state_o.last_pid     = pid_next;
              count_o              = '0;
              emit_o               = 1'b1;
              result_o.request_pid = pid_next;
            end
          end
        end
        PH_FAULT: begin
          emit_o = 1'b0;
        end
        default: begin
          emit_o = 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/obd_pid_poll_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// OBD-II mode 01 PID poll sequencer
// Discovers the supported-PID bitmap and then requests the controlled PIDs
// in round-robin order, one request per poll period.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries words that are either one timer tick or one
//   received CAN frame. The output channel carries request words: a PID to
//   send in a 0x7DF frame (02 01 pid), or a one-time fault report.
//   Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i
//   while the block is idle.
//   A result appears on out_valid_o after its input word passes the input
//   register, then the result register. Throughput is one word per cycle
//   while the receiver does not stall; the step logic is a single pass from
//   the input register to the result register.
//   Words that cause no result simply leave the pipeline.
//   When the receiver stalls, the result register holds; an empty input register
//   still takes one more word, then in_stall_o rises until the result moves.
//   Reset clears the block to discovery with the first request pending and
//   restores the register defaults; a fault is sticky until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module obd_pid_poll_sequencer_unit #(
  parameter int TIMER_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire obdpps_pkg::in_word_t  in_word_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      obdpps_pkg::out_word_t out_word_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_idx_i,
  input  wire logic [31:0]           cfg_data_i
);
  import obdpps_pkg::*;

  logic                  in_valid_q, in_valid_d;
  in_word_t              in_q;
  logic                  out_valid_q, out_valid_d;
  out_word_t             out_q;
  cfg_t                  cfg_q, cfg_d;
  seq_state_t            state_q, state_d;
  logic [TIMER_BITS-1:0] count_q, count_d;
  logic                  adv_stall;
  logic                  in_take;
  logic                  fire;
  logic                  emit;
  out_word_t             result;

  // Handshake: the input register moves on when the result register is free.
  assign adv_stall  = out_valid_q && out_stall_i;
  assign in_stall_o = in_valid_q && adv_stall;
  assign in_take    = in_valid_i && !in_stall_o;
  assign fire       = in_valid_q && !adv_stall;

  assign in_valid_d  = in_take ? 1'b1 : (fire ? 1'b0 : in_valid_q);
  assign out_valid_d = fire ? emit : (out_stall_i ? out_valid_q : 1'b0);

  // Configuration register decode.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CHECKED_MASK: cfg_d.checked_pid_mask       = cfg_data_i;
        CFG_TRIES:        cfg_d.discovery_tries        = cfg_data_i[3:0];
        CFG_TIMEOUT:      cfg_d.response_timeout_ticks = cfg_data_i[15:0];
        CFG_PERIOD:       cfg_d.poll_period_ticks      = cfg_data_i[15:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  // Sequencer step between the input and result registers.
  obdpps_step #(
    .TIMER_BITS(TIMER_BITS)
  ) u_step (
    .fire_i   (fire),
    .word_i   (in_q),
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .count_i  (count_q),
    .state_o  (state_d),
    .count_o  (count_d),
    .emit_o   (emit),
    .result_o (result)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cfg_q       <= '{checked_pid_mask: CHECKED_MASK_RST, discovery_tries: TRIES_RST,
                       response_timeout_ticks: TIMEOUT_RST, poll_period_ticks: PERIOD_RST};
      state_q     <= '{phase: PH_PENDING, tries_used: 4'd0, controlled: 32'd0,
                       last_pid: 6'd0};
      count_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      cfg_q       <= cfg_d;
      state_q     <= state_d;
      count_q     <= count_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_word_i;
    end
    if (fire && emit) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

// ----- rtl/obdpps_checker.sv -----
// ----------------------------------------------------------------------------
// OBD-II PID poll sequencer port checker
// Watches the top-level ports for result words that break the sequencing
// rules, and is bound to every instance of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module obdpps_checker (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire obdpps_pkg::out_word_t out_word_o
);
  import obdpps_pkg::*;

  logic fault_seen_q;

  // Remember that a fault word has been delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_seen_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i && (out_word_o.fault_code != FAULT_NONE)) begin
      fault_seen_q <= 1'b1;
    end
  end

  // A stalled result word stays valid and unchanged.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // A fault report carries no PID.
  a_fault_pid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.fault_code != FAULT_NONE) |-> out_word_o.request_pid == 6'd0)
    else $error("fault word carries a PID");

  // A polled PID is a member of the controlled set.
  a_pid_member: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.request_pid != 6'd0) |->
      (out_word_o.request_pid <= 6'd32) &&
      ((out_word_o.controlled_pids & (32'h8000_0000 >> (out_word_o.request_pid - 6'd1)))
        != 32'd0))
    else $error("requested PID is not in the controlled set");

  // After the fault word has gone out, the block stays silent.
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_seen_q |-> !out_valid_o)
    else $error("result word after fault");

endmodule

bind obd_pid_poll_sequencer_unit obdpps_checker u_obdpps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire

// ----- dv/obdpps_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID poll sequencer scoreboard
// Tracks the discovery and polling behavior of the sequencer, predicts the
// request words that each accepted input word causes and checks every
// result word against them in order.
// ----------------------------------------------------------------------------

package obdpps_tb_pkg;

  import obdpps_pkg::*;

  // The tick counters saturate at this value.
  localparam logic [15:0] TICK_COUNT_TOP = 16'hFFFF;

  class pid_request_scoreboard;

    // Register copies.
    logic [31:0] pid_mask;
    logic [3:0]  tries_limit;
    logic [15:0] timeout_ticks;
    logic [15:0] period_ticks;

    // Sequencer state.
    phase_e      phase;
    logic [3:0]  tries_used;
    logic [15:0] wait_cnt;
    logic [15:0] poll_cnt;
    logic [31:0] controlled;
    logic [5:0]  last_pid;

    out_word_t   pending_requests[$];
    int unsigned mismatches;

    function new();
      pid_mask      = CHECKED_MASK_RST;
      tries_limit   = TRIES_RST;
      timeout_ticks = TIMEOUT_RST;
      period_ticks  = PERIOD_RST;
      phase         = PH_PENDING;
      tries_used    = '0;
      wait_cnt      = '0;
      poll_cnt      = '0;
      controlled    = '0;
      last_pid      = '0;
      mismatches    = 0;
    endfunction

    // Only the register's own width is kept from the write data.
    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CFG_CHECKED_MASK: pid_mask = data;
        CFG_TRIES:        tries_limit = data[3:0];
        CFG_TIMEOUT:      timeout_ticks = data[15:0];
        CFG_PERIOD:       period_ticks = data[15:0];
      endcase
    endfunction

    function void push_request(logic [5:0] pid, logic [1:0] fault);
      out_word_t w;
      w.request_pid     = pid;
      w.fault_code      = fault;
      w.controlled_pids = controlled;
      pending_requests.push_back(w);
    endfunction

    // Counts one tick; a zero threshold acts as one, saturation always fires.
    function bit count_tick(inout logic [15:0] cnt, input logic [15:0] limit);
      if (cnt != TICK_COUNT_TOP) cnt = cnt + 16'd1;
      return (cnt >= ((limit == '0) ? 16'd1 : limit)) || (cnt == TICK_COUNT_TOP);
    endfunction

    // Round-robin search from the PID after the last one; PID p is bit 32-p.
    function void issue_poll();
      logic [4:0] bitpos;
      bitpos = last_pid[4:0];
      for (int k = 0; k < 32; k++) begin
        if (controlled[5'd31 - bitpos]) break;
        bitpos = bitpos + 5'd1;
      end
      last_pid = {1'b0, bitpos} + 6'd1;
      poll_cnt = '0;
      push_request(last_pid, FAULT_NONE);
    endfunction

    function void note_accepted_word(in_word_t w);
      logic is_answer;
      if (phase == PH_FAULT) return;
      if (w.opcode == OP_FRAME) begin
        // Only a supported-PID answer during discovery has any effect.
        is_answer = (phase != PH_POLL) && (w.frame_id >= RESP_ID_LOW) &&
                    (w.frame_id <= RESP_ID_HIGH) && (w.frame_length == RESP_DLC) &&
                    (w.byte_zero > RESP_MIN_LEN) && (w.byte_one == MODE01_REPLY) &&
                    (w.byte_two == PID_SUPPORTED);
        if (!is_answer) return;
        controlled = {w.byte_three, w.byte_four, w.byte_five, w.byte_six} & pid_mask;
        if (controlled == '0) begin
          phase = PH_FAULT;
          push_request('0, FAULT_NO_PIDS);
        end else begin
          phase = PH_POLL;
          issue_poll();
        end
      end else begin
        case (phase)
          PH_PENDING: begin
            phase      = PH_WAIT;
            tries_used = 4'd1;
            wait_cnt   = '0;
            push_request('0, FAULT_NONE);
          end
          PH_WAIT: begin
            if (count_tick(wait_cnt, timeout_ticks)) begin
              wait_cnt = '0;
              if (tries_used < tries_limit) begin
                tries_used = tries_used + 4'd1;
                push_request('0, FAULT_NONE);
              end else begin
                phase = PH_FAULT;
                push_request('0, FAULT_NO_RESPONSE);
              end
            end
          end
          default: begin
            if (count_tick(poll_cnt, period_ticks)) issue_poll();
          end
        endcase
      end
    endfunction

    function void check_request_word(out_word_t got);
      out_word_t exp;
      if (pending_requests.size() == 0) begin
        $error("unexpected request word: request_pid %0d fault_code %0d controlled_pids %08h",
               got.request_pid, got.fault_code, got.controlled_pids);
        mismatches++;
        return;
      end
      exp = pending_requests.pop_front();
      if (got.request_pid !== exp.request_pid) begin
        $error("request_pid: expected %0d, actual %0d", exp.request_pid, got.request_pid);
        mismatches++;
      end
      if (got.fault_code !== exp.fault_code) begin
        $error("fault_code: expected %0d, actual %0d", exp.fault_code, got.fault_code);
        mismatches++;
      end
      if (got.controlled_pids !== exp.controlled_pids) begin
        $error("controlled_pids: expected %08h, actual %08h",
               exp.controlled_pids, got.controlled_pids);
        mismatches++;
      end
    endfunction

  endclass

endpackage

// ----- dv/tb_obd_pid_poll_sequencer_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID poll sequencer testbench
// Walks the sequencer through discovery with near-miss answers, retries and
// register extremes, then polls under changing periods with random ticks and
// frames. Either side idles at random; every result word is checked in order.
// ----------------------------------------------------------------------------

module tb_obd_pid_poll_sequencer_unit;

  import obdpps_pkg::*;
  import obdpps_tb_pkg::*;

  // Sender and receiver windows without random idling; long receiver holds still apply.
  localparam int unsigned CALM_ITEM_FROM  = 800;
  localparam int unsigned CALM_ITEM_TO    = 1100;
  localparam int unsigned QUIET_CYCLE_FROM = 1000;
  localparam int unsigned QUIET_CYCLE_TO   = 1800;
  localparam int unsigned ITEM_TARGET     = 1950;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CFG_CHECKED_MASK;
  logic [31:0] cfg_data = '0;

  pid_request_scoreboard sb;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 0;

  obd_pid_poll_sequencer_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Word with all fields random and the given opcode.
  function automatic in_word_t random_word(logic opcode);
    logic [95:0] bits;
    in_word_t    w;
    bits = {$urandom(), $urandom(), $urandom()};
    w = bits[71:0];
    w.opcode = opcode;
    return w;
  endfunction

  // Well-formed supported-PID answer carrying the given bitmap.
  function automatic in_word_t answer_word(logic [31:0] bitmap);
    in_word_t w;
    w = random_word(OP_FRAME);
    w.frame_id     = RESP_ID_LOW + 11'($urandom_range(7));
    w.frame_length = RESP_DLC;
    w.byte_zero    = 8'($urandom_range(255, 3));
    w.byte_one     = MODE01_REPLY;
    w.byte_two     = PID_SUPPORTED;
    {w.byte_three, w.byte_four, w.byte_five, w.byte_six} = bitmap;
    return w;
  endfunction

  function automatic logic [15:0] pick_period();
    logic [15:0] p;
    case ($urandom_range(9))
      0:       p = '0;
      1:       p = 16'hFFFF;
      2:       p = 16'd1;
      3, 4:    p = 16'($urandom_range(3, 2));
      5, 6, 7: p = 16'($urandom_range(8, 1));
      default: p = 16'($urandom_range(40, 9));
    endcase
    return p;
  endfunction

  function automatic logic [31:0] pick_mask();
    logic [31:0] m;
    case ($urandom_range(5))
      0:       m = CHECKED_MASK_RST;
      1:       m = '1;
      2:       m = 32'h8000_0001;
      3:       m = '0;
      default: m = $urandom();
    endcase
    return m;
  endfunction

  // Offers one word, with an occasional idle gap first, and holds it until taken.
  task automatic send_word(input in_word_t w);
    if ((items_sent < CALM_ITEM_FROM || items_sent >= CALM_ITEM_TO) &&
        $urandom_range(99) < 3) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    sb.note_accepted_word(w);
    items_sent++;
  endtask

  // Lets every expected word arrive, then lets silent words leave the pipeline.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_requests.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Writes all four registers; unused upper data bits carry noise.
  task automatic program_regs(input logic [31:0] mask, input logic [3:0] tries,
                              input logic [15:0] timeout, input logic [15:0] period);
    write_cfg(CFG_CHECKED_MASK, mask);
    write_cfg(CFG_TRIES, {28'($urandom()), tries});
    write_cfg(CFG_TIMEOUT, {16'($urandom()), timeout});
    write_cfg(CFG_PERIOD, {16'($urandom()), period});
    cfg_we <= 1'b0;
  endtask

  // Receiver: checks accepted words, stalls at random, and now and then holds
  // off for a long stretch while the sender keeps offering words.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_request_word(out_word);
      results_seen++;
    end
    rx_cycle++;
    if (hold_left == 0 && results_seen >= next_hold_at && in_valid) begin
      hold_left = 200;
      next_hold_at += 500;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_cycle >= QUIET_CYCLE_FROM && rx_cycle < QUIET_CYCLE_TO) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 6);
    end
  end

  initial begin
    in_word_t    w;
    logic [31:0] mask;
    logic [31:0] bitmap;
    logic [3:0]  tries;
    logic [15:0] period;
    logic [15:0] timeout;
    int unsigned fault_kind;
    int unsigned eff_tries;
    int unsigned n;
    int unsigned r;
    int unsigned stop_at;

    sb = new();

    // The seed picks how discovery ends: no response, empty set, or polling.
    fault_kind = $urandom_range(9);
    mask = pick_mask();
    if (fault_kind != 1 && mask == '0) mask = CHECKED_MASK_RST;
    bitmap = $urandom();
    if ($urandom_range(1) == 1) bitmap |= 32'h8000_0001;
    if (fault_kind == 1) begin
      bitmap = ~mask;
    end else if ((bitmap & mask) == '0) begin
      bitmap = mask;
    end
    r = $urandom_range(4);
    tries = (r == 4) ? 4'd15 : 4'(r);
    eff_tries = (tries == '0) ? 1 : tries;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Near-miss answers, each failing one check, around the first request.
    for (int i = 0; i < 10; i++) begin
      if (i == 5) send_word(random_word(OP_TICK));
      w = answer_word($urandom());
      case (i)
        0:       w.frame_id = RESP_ID_LOW - 11'd1;
        1:       w.frame_id = RESP_ID_HIGH + 11'd1;
        2:       w.frame_id = '1;
        3:       w.frame_length = RESP_DLC - 4'd1;
        4:       w.frame_length = RESP_DLC + 4'd1;
        5:       w.frame_length = '0;
        6:       w.byte_zero = RESP_MIN_LEN;
        7:       w.byte_zero = '0;
        8:       w.byte_one = MODE01_REPLY ^ 8'h01;
        default: w.byte_two = PID_SUPPORTED + 8'd1;
      endcase
      send_word(w);
    end

    // With the longest timeout a few ticks do not retry.
    drain();
    program_regs(mask, tries, 16'hFFFF, PERIOD_RST);
    repeat (3) send_word(random_word(OP_TICK));

    // A zero timeout acts as one tick, so every tick retries until the tries run out.
    drain();
    program_regs(mask, tries, '0, pick_period());
    repeat (eff_tries - 1 + ((fault_kind == 0) ? 2 : 0)) send_word(random_word(OP_TICK));
    if (fault_kind != 0) send_word(answer_word(bitmap));

    // Random phases, each under its own register setting.
    stop_at = ITEM_TARGET;
    while (items_sent < stop_at) begin
      drain();
      period = pick_period();
      case ($urandom_range(3))
        0:       timeout = '0;
        1:       timeout = 16'hFFFF;
        default: timeout = 16'($urandom());
      endcase
      program_regs(pick_mask(), 4'($urandom_range(15)), timeout, period);
      n = (period == 16'hFFFF) ? 20 : $urandom_range(200, 60);
      repeat (n) begin
        r = $urandom_range(99);
        if (r < 80) begin
          w = random_word(OP_TICK);
        end else if (r < 90) begin
          w = answer_word($urandom());
        end else begin
          w = random_word(OP_FRAME);
        end
        send_word(w);
      end
    end

    drain();
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
